// ----- rtl/vda_pkg.sv -----
// Shared types, sizes, register codes and the scale table for the vector distance accumulator.
// Has no dependencies. Every other file in rtl/ refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package vda_pkg;

    // Sizing
    localparam int MAX_DIM      = 4096;
    localparam int ELEM_W       = 16;
    localparam int OP_W         = 17;                    // decoded element or difference
    localparam int PROD_W       = 2 * OP_W;              // full signed product
    localparam int ACC_W        = 48;
    localparam int ELEM_COUNT_W = 13;
    localparam int PC_W         = $clog2(MAX_DIM + 1);   // internal pair counter
    localparam int ETYPE_W      = 2;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 2;
    localparam int Q_DEPTH      = 4;
    localparam int Q_PTR_W      = $clog2(Q_DEPTH);
    localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

    // Element type codes. The fourth code is decoded as signed 16-bit.
    localparam logic [ETYPE_W-1:0] ETYPE_U8  = 2'd0;
    localparam logic [ETYPE_W-1:0] ETYPE_S8  = 2'd1;
    localparam logic [ETYPE_W-1:0] ETYPE_S16 = 2'd2;

    // Metric codes
    localparam logic METRIC_L2  = 1'b0;
    localparam logic METRIC_COS = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_TYPE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_METRIC       = 1'b1;

    typedef struct packed {
        logic [ELEM_W-1:0] x_elem;
        logic [ELEM_W-1:0] y_elem;
        logic              last;
    } vda_in_t;

    typedef struct packed {
        logic signed [ACC_W-1:0]  distance;
        logic [ELEM_COUNT_W-1:0]  element_count;
        logic                     too_long;
    } vda_out_t;

    // One classified word waiting in the queue: multiplier operands plus the
    // settings that were live when it was accepted.
    typedef struct packed {
        logic signed [OP_W-1:0] op_a;
        logic signed [OP_W-1:0] op_b;
        logic                   metric;
        logic [ETYPE_W-1:0]     etype;
        logic                   last;
    } vda_work_t;

    typedef struct packed {
        logic empty;
        logic full;
    } vda_q_stat_t;

    function automatic logic [ACC_W-1:0] scale_of(input logic [ETYPE_W-1:0] et);
        logic [ACC_W-1:0] s;
        unique case (et)
            ETYPE_U8: s = ACC_W'(255 * 255);
            ETYPE_S8: s = ACC_W'(127 * 127);
            default:  s = ACC_W'(64'd32767 * 64'd32767);
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/vda_front.sv -----
// Front end: decodes raw element bits under the live element type and forms multiplier operands.
// Depends on vda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vda_front (
    input  wire vda_pkg::vda_in_t                 in_word,
    input  wire logic [vda_pkg::ETYPE_W-1:0]      etype,
    input  wire logic                             metric,
    output vda_pkg::vda_work_t                    work
);

    function automatic logic signed [vda_pkg::OP_W-1:0] decode_elem(
        input logic [vda_pkg::ELEM_W-1:0] raw,
        input logic [vda_pkg::ETYPE_W-1:0] et
    );
        logic signed [vda_pkg::OP_W-1:0] v;
        unique case (et)
            vda_pkg::ETYPE_U8: v = {{(vda_pkg::OP_W-8){1'b0}}, raw[7:0]};
            vda_pkg::ETYPE_S8: v = {{(vda_pkg::OP_W-8){raw[7]}}, raw[7:0]};
            default:           v = {{(vda_pkg::OP_W-16){raw[15]}}, raw[15:0]};
        endcase
        return v;
    endfunction

    logic signed [vda_pkg::OP_W-1:0] x_val;
    logic signed [vda_pkg::OP_W-1:0] y_val;
    logic signed [vda_pkg::OP_W-1:0] diff;

    // The difference of two 16-bit signed values always fits in 17 bits.
    always_comb begin
        x_val = decode_elem(in_word.x_elem, etype);
        y_val = decode_elem(in_word.y_elem, etype);
        diff  = x_val - y_val;
        if (metric == vda_pkg::METRIC_COS) begin
            work.op_a = x_val;
            work.op_b = y_val;
        end else begin
            work.op_a = diff;
            work.op_b = diff;
        end
        work.metric = metric;
        work.etype  = etype;
        work.last   = in_word.last;
    end

endmodule

`default_nettype wire

// ----- rtl/vda_queue.sv -----
// Small circular queue of classified words between the front end and the back end.
// Depends on vda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vda_queue (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire vda_pkg::vda_work_t    wr_word,
    input  wire logic                  pop,
    output vda_pkg::vda_work_t         rd_word,
    output vda_pkg::vda_q_stat_t       stat
);

    vda_pkg::vda_work_t            mem_reg [vda_pkg::Q_DEPTH];
    logic [vda_pkg::Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [vda_pkg::Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [vda_pkg::Q_CNT_W-1:0]   cnt_reg, cnt_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_word;
        end
    end

    assign rd_word    = mem_reg[rd_ptr_reg];
    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == vda_pkg::Q_CNT_W'(vda_pkg::Q_DEPTH));

endmodule

`default_nettype wire

// ----- rtl/vda_back.sv -----
// Back end: registered multiply, accumulate with pair counting, and the result output register.
// Depends on vda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vda_back (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire vda_pkg::vda_work_t    head,
    input  wire vda_pkg::vda_q_stat_t  q_stat,
    output logic                       q_pop,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output vda_pkg::vda_out_t          m_data
);

    // Multiply stage
    logic                               mul_vld_reg;
    logic signed [vda_pkg::PROD_W-1:0]  term_reg;
    logic                               mul_last_reg;
    logic                               mul_metric_reg;
    logic [vda_pkg::ETYPE_W-1:0]        mul_etype_reg;

    // Accumulation state
    logic [vda_pkg::ACC_W-1:0]          acc_reg, acc_next;
    logic [vda_pkg::PC_W-1:0]           pc_reg, pc_next;
    logic                               ovl_reg, ovl_next;

    // Output register
    logic                               out_vld_reg;
    vda_pkg::vda_out_t                  out_reg;

    logic                               out_free;
    logic                               adv;
    logic                               mul_take;
    logic signed [vda_pkg::PROD_W-1:0]  prod;
    logic                               in_range;
    logic [vda_pkg::ACC_W-1:0]          addend;
    logic [vda_pkg::ACC_W-1:0]          acc_sum;
    logic [vda_pkg::PC_W-1:0]           pc_sum;
    logic                               ovl_sum;
    logic [vda_pkg::ACC_W-1:0]          dist_value;

    assign out_free = !out_vld_reg || m_ready;
    assign adv      = mul_vld_reg && (!mul_last_reg || out_free);
    assign mul_take = !mul_vld_reg || adv;
    assign q_pop    = !q_stat.empty && mul_take;
    assign prod     = head.op_a * head.op_b;

    always_comb begin
        in_range = (pc_reg < vda_pkg::PC_W'(vda_pkg::MAX_DIM));
        addend   = in_range
                 ? {{(vda_pkg::ACC_W-vda_pkg::PROD_W){term_reg[vda_pkg::PROD_W-1]}}, term_reg}
                 : '0;
        acc_sum  = acc_reg + addend;
        pc_sum   = in_range ? vda_pkg::PC_W'(pc_reg + 1'b1) : pc_reg;
        ovl_sum  = ovl_reg | !in_range;
        // In cosine mode the result is the scale minus the sum including this last term.
        if (mul_metric_reg == vda_pkg::METRIC_COS) begin
            dist_value = vda_pkg::scale_of(mul_etype_reg) - acc_reg - addend;
        end else begin
            dist_value = acc_sum;
        end

        acc_next = acc_reg;
        pc_next  = pc_reg;
        ovl_next = ovl_reg;
        if (adv) begin
            if (mul_last_reg) begin
                acc_next = '0;
                pc_next  = '0;
                ovl_next = 1'b0;
            end else begin
                acc_next = acc_sum;
                pc_next  = pc_sum;
                ovl_next = ovl_sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_vld_reg <= 1'b0;
            acc_reg     <= '0;
            pc_reg      <= '0;
            ovl_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (mul_take) begin
                mul_vld_reg <= q_pop;
            end
            acc_reg <= acc_next;
            pc_reg  <= pc_next;
            ovl_reg <= ovl_next;
            if (adv && mul_last_reg) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            term_reg       <= prod;
            mul_last_reg   <= head.last;
            mul_metric_reg <= head.metric;
            mul_etype_reg  <= head.etype;
        end
        if (adv && mul_last_reg) begin
            out_reg.distance      <= dist_value;
            out_reg.element_count <= vda_pkg::ELEM_COUNT_W'(pc_sum);
            out_reg.too_long      <= ovl_sum;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

// ----- rtl/vector_distance_accumulator.sv -----
// Top level of the vector distance accumulator: configuration registers and the
// front end, queue and back end. Depends on vda_pkg, vda_front, vda_queue, vda_back.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                        Word
// --------  ---------------------------  -----------------------------------------
// input     s_valid, s_ready, s_data     x_elem, y_elem, last   (vda_in_t)
// result    m_valid, m_ready, m_data     distance, element_count, too_long (vda_out_t)
// config    cfg_we, cfg_index, cfg_wdata 0: element_type, 1: metric; write only
//
// One input word is accepted per cycle while the queue is not full. A word marked last
// produces its result on m_valid after the queue read, the registered 17 x 17
// multiplier ahead of the accumulator and the output register.
// Reset (aresetn low, synchronous) clears the queue, the accumulation state, the
// output valid flag and both configuration registers.
// A stalled result holds the back end only when the next word to retire is also
// marked last; the four-entry queue absorbs the rest, and s_ready drops when it fills.
module vector_distance_accumulator (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire vda_pkg::vda_in_t                s_data,

    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output vda_pkg::vda_out_t                    m_data,

    input  wire logic                            cfg_we,
    input  wire logic [vda_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [vda_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    // Configuration registers. Every word carries the values live when it is
    // accepted, so a write between vectors never touches words already queued.
    logic [vda_pkg::ETYPE_W-1:0]  etype_reg;
    logic                         metric_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            etype_reg  <= vda_pkg::ETYPE_U8;
            metric_reg <= vda_pkg::METRIC_L2;
        end else if (cfg_we) begin
            unique case (cfg_index)
                vda_pkg::REG_ELEMENT_TYPE: etype_reg  <= cfg_wdata[vda_pkg::ETYPE_W-1:0];
                vda_pkg::REG_METRIC:       metric_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    vda_pkg::vda_work_t    front_word;
    vda_pkg::vda_work_t    head_word;
    vda_pkg::vda_q_stat_t  q_stat;
    logic                  q_push;
    logic                  q_pop;

    // The front end decodes the word the moment it is accepted.
    vda_front u_front (
        .in_word (s_data),
        .etype   (etype_reg),
        .metric  (metric_reg),
        .work    (front_word)
    );

    assign s_ready = !q_stat.full;
    assign q_push  = s_valid && s_ready;

    vda_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_word (front_word),
        .pop     (q_pop),
        .rd_word (head_word),
        .stat    (q_stat)
    );

    // The back end multiplies, accumulates and presents the result word.
    vda_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head_word),
        .q_stat  (q_stat),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // A result is never presented in the cycle right after reset.
    a_no_result_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A new result always follows a queue read, through the multiply register and the output register.
    a_result_follows_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(q_pop, 2))
        else $error("result appeared without a word leaving the queue");

    // An overlong vector always reports the count saturated at the limit.
    a_too_long_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.too_long)
            |-> (m_data.element_count == vda_pkg::ELEM_COUNT_W'(vda_pkg::MAX_DIM)))
        else $error("too_long set with an unsaturated element count");

    // The reported count never goes past the limit.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.element_count <= vda_pkg::ELEM_COUNT_W'(vda_pkg::MAX_DIM)))
        else $error("element count beyond the maximum dimension");

endmodule

`default_nettype wire

// ----- bench/vda_checker.sv -----
// Scoreboard for the vector distance accumulator: watches the input, result and register ports,
// predicts each result word and compares it field by field. Depends on vda_pkg.
`timescale 1ns / 1ps

module vda_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  vda_pkg::vda_in_t               s_data,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  vda_pkg::vda_out_t              m_data,
    input  logic                           cfg_we,
    input  logic [vda_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vda_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                             mismatches,
    output int                             open_results,
    output int                             words_seen,
    output int                             results_seen
);
    import vda_pkg::*;

    // Live settings and the running sum of the vector in flight.
    logic [ETYPE_W-1:0] cur_type;
    logic               cur_metric;
    logic [ACC_W-1:0]   running_sum;
    int                 pairs_taken;
    logic               overflowed;

    vda_out_t pending_distances[$];
    int       error_total;
    int       word_total;
    int       result_total;

    initial begin
        error_total  = 0;
        word_total   = 0;
        result_total = 0;
        mismatches   = 0;
        open_results = 0;
        words_seen   = 0;
        results_seen = 0;
    end

    function automatic longint elem_value(input logic [ELEM_W-1:0] raw,
                                          input logic [ETYPE_W-1:0] et);
        case (et)
            ETYPE_U8: return longint'(raw[7:0]);
            ETYPE_S8: return longint'($signed(raw[7:0]));
            default:  return longint'($signed(raw));
        endcase
    endfunction

    function automatic logic [ACC_W-1:0] scale_for(input logic [ETYPE_W-1:0] et);
        case (et)
            ETYPE_U8: return ACC_W'(255 * 255);
            ETYPE_S8: return ACC_W'(127 * 127);
            default:  return ACC_W'(32767 * 32767);
        endcase
    endfunction

    // Folds one element pair into the sum; a word marked last yields the expected result.
    task automatic absorb_pair(input vda_in_t w);
        longint   x;
        longint   y;
        longint   term;
        vda_out_t want;
        x = elem_value(w.x_elem, cur_type);
        y = elem_value(w.y_elem, cur_type);
        if (pairs_taken < MAX_DIM) begin
            term = (cur_metric == METRIC_L2) ? (x - y) * (x - y) : x * y;
            running_sum = running_sum + ACC_W'(term);
            pairs_taken++;
        end else begin
            overflowed = 1'b1;
        end
        if (w.last) begin
            want.distance      = (cur_metric == METRIC_L2) ? running_sum
                                                           : scale_for(cur_type) - running_sum;
            want.element_count = ELEM_COUNT_W'(pairs_taken);
            want.too_long      = overflowed;
            pending_distances.push_back(want);
            running_sum = '0;
            pairs_taken = 0;
            overflowed  = 1'b0;
        end
    endtask

    always @(posedge aclk) begin
        vda_out_t want;
        if (!aresetn) begin
            cur_type    = ETYPE_U8;
            cur_metric  = METRIC_L2;
            running_sum = '0;
            pairs_taken = 0;
            overflowed  = 1'b0;
            pending_distances.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_ELEMENT_TYPE: cur_type   = cfg_wdata[ETYPE_W-1:0];
                    REG_METRIC:       cur_metric = cfg_wdata[0];
                    default:          ;
                endcase
            end
            if (s_valid && s_ready) begin
                word_total++;
                absorb_pair(s_data);
            end
            if (m_valid && m_ready) begin
                result_total++;
                if (pending_distances.size() == 0) begin
                    $error("Unexpected result word: distance %0d, element_count %0d, too_long %0b",
                           m_data.distance, m_data.element_count, m_data.too_long);
                    error_total++;
                end else begin
                    want = pending_distances.pop_front();
                    if (m_data.distance !== want.distance) begin
                        $error("distance: expected %0d, actual %0d",
                               want.distance, m_data.distance);
                        error_total++;
                    end
                    if (m_data.element_count !== want.element_count) begin
                        $error("element_count: expected %0d, actual %0d",
                               want.element_count, m_data.element_count);
                        error_total++;
                    end
                    if (m_data.too_long !== want.too_long) begin
                        $error("too_long: expected %0b, actual %0b",
                               want.too_long, m_data.too_long);
                        error_total++;
                    end
                end
            end
        end
        // Published with nonblocking updates so the stimulus side reads settled values.
        mismatches   <= error_total;
        open_results <= pending_distances.size();
        words_seen   <= word_total;
        results_seen <= result_total;
    end

endmodule

// ----- bench/vector_distance_accumulator_test.sv -----
// Top of the vector distance accumulator testbench: clock, reset, stimulus, result-side
// back-pressure and the verdict. Depends on vda_pkg, vda_checker and the block itself.
`timescale 1ns / 1ps

module vector_distance_accumulator_test;
    import vda_pkg::*;

    // The fourth element type code has no name in the package; it must behave as signed 16-bit.
    localparam logic [ETYPE_W-1:0] ETYPE_RESERVED = 2'd3;
    localparam int RANDOM_WORDS = 1840;
    localparam int IDLE_PCT     = 12;
    localparam int HOLD_CYCLES  = 400;
    // Cycles to wait after the last result so that words without a result leave the queue.
    localparam int SETTLE_CYCLES = 16;

    logic     aclk      = 1'b0;
    logic     aresetn   = 1'b0;
    logic     s_valid   = 1'b0;
    logic     s_ready;
    vda_in_t  s_data    = '0;
    logic     m_valid;
    logic     m_ready   = 1'b0;
    vda_out_t m_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int mismatches;
    int open_results;
    int words_seen;
    int results_seen;

    // Shared between the stimulus and the receiver: a steady stretch turns off idling on
    // both sides, and the pressure window asks the receiver for one long hold-off.
    bit steady     = 1'b0;
    bit pressure_on = 1'b0;
    int word_count  = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    vector_distance_accumulator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    vda_checker scoreboard (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .mismatches   (mismatches),
        .open_results (open_results),
        .words_seen   (words_seen),
        .results_seen (results_seen)
    );

    // Offers one word and returns just after the edge that accepted it. Valid is raised
    // only after any idle gap, so it never drops while a word is waiting.
    task automatic offer_word(input vda_in_t word_in);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= word_in;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        word_count++;
    endtask

    // Stops offering, waits until every predicted result has come back, then lets the
    // queue empty of words that produce no result. The block is idle afterwards.
    task automatic drain_and_settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (open_results != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes both registers on consecutive edges. The metric write carries a second data
    // bit that the block must ignore.
    task automatic load_settings(input logic [ETYPE_W-1:0] et,
                                 input logic [CFG_DATA_W-1:0] metric_raw);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ELEMENT_TYPE;
        cfg_wdata <= et;
        @(posedge aclk);
        cfg_index <= REG_METRIC;
        cfg_wdata <= metric_raw;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic load_random_settings();
        load_settings(ETYPE_W'($urandom_range(3)), CFG_DATA_W'($urandom_range(3)));
    endtask

    // Element values lean toward the range ends of every type; the rest are fully random,
    // upper byte included, so the ignored bits of the 8-bit types are exercised too.
    function automatic logic [ELEM_W-1:0] pick_elem();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0080;
            3:       return 16'h007F;
            4:       return 16'h00FF;
            5:       return 16'hFFFF;
            6:       return 16'h0000;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    // A one-word vector under the given settings, for the directed checks.
    task automatic probe_pair(input logic [ETYPE_W-1:0] et, input logic metric,
                              input logic [ELEM_W-1:0] x, input logic [ELEM_W-1:0] y);
        drain_and_settle();
        load_settings(et, {1'b0, metric});
        offer_word('{x_elem: x, y_elem: y, last: 1'b1});
    endtask

    // Sends one vector. With extremes set it alternates the most negative and most positive
    // 16-bit values, the largest squared differences. Rarely, the block is drained in the
    // middle of a vector and the settings change before the rest of it.
    task automatic stream_vector(input int len, input bit extremes);
        logic [ELEM_W-1:0] xv;
        logic [ELEM_W-1:0] yv;
        for (int i = 0; i < len; i++) begin
            if (!extremes && i > 0 && $urandom_range(199) == 0) begin
                drain_and_settle();
                load_random_settings();
            end
            if (extremes) begin
                xv = i[0] ? 16'h8000 : 16'h7FFF;
                yv = i[0] ? 16'h7FFF : 16'h8000;
            end else begin
                xv = pick_elem();
                yv = pick_elem();
            end
            offer_word('{x_elem: xv, y_elem: yv, last: (i == len - 1)});
        end
    endtask

    // Result side. Ready is random except in the steady stretch; once, while the pressure
    // window is open, it stays low for a long count so the queue fills and s_ready drops.
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (pressure_on && !hold_done) begin
                m_ready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        int len;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed checks: range ends of each type under both metrics. The upper byte of
        // an 8-bit element is ignored, a cosine result can go negative, and the reserved
        // type code decodes as signed 16-bit.
        probe_pair(ETYPE_U8,       METRIC_L2,  16'hABFF, 16'h5400);
        probe_pair(ETYPE_U8,       METRIC_COS, 16'h00FF, 16'hFFFF);
        probe_pair(ETYPE_U8,       METRIC_COS, 16'h0000, 16'h0000);
        probe_pair(ETYPE_S8,       METRIC_L2,  16'h0080, 16'h007F);
        probe_pair(ETYPE_S8,       METRIC_COS, 16'hFF80, 16'h0080);
        probe_pair(ETYPE_S8,       METRIC_COS, 16'h007F, 16'h7F7F);
        probe_pair(ETYPE_S16,      METRIC_L2,  16'h8000, 16'h7FFF);
        probe_pair(ETYPE_S16,      METRIC_COS, 16'h8000, 16'h8000);
        probe_pair(ETYPE_S16,      METRIC_COS, 16'h7FFF, 16'h7FFF);
        probe_pair(ETYPE_RESERVED, METRIC_L2,  16'h8000, 16'h7FFF);
        probe_pair(ETYPE_RESERVED, METRIC_COS, 16'h8001, 16'h7FFF);

        // A short vector under signed 8-bit, with the metric written as 2'b11 so only its
        // low bit should count.
        drain_and_settle();
        load_settings(ETYPE_S8, 2'b11);
        offer_word('{x_elem: 16'h0001, y_elem: 16'h00FF, last: 1'b0});
        offer_word('{x_elem: 16'h0080, y_elem: 16'h0002, last: 1'b0});
        offer_word('{x_elem: 16'h007F, y_elem: 16'h0080, last: 1'b1});

        // Settings changed halfway through a vector: each pair uses the values live at its
        // arrival and the result follows those of the last word.
        drain_and_settle();
        load_settings(ETYPE_U8, {1'b0, METRIC_L2});
        offer_word('{x_elem: 16'h00FF, y_elem: 16'h0001, last: 1'b0});
        offer_word('{x_elem: 16'h0010, y_elem: 16'h0080, last: 1'b0});
        drain_and_settle();
        load_settings(ETYPE_S16, {1'b0, METRIC_COS});
        offer_word('{x_elem: 16'hC000, y_elem: 16'h4000, last: 1'b1});

        // Random vectors, mostly short, sometimes reaching a few dozen words.
        word_count = 0;
        while (word_count < RANDOM_WORDS) begin
            steady = (word_count >= 700 && word_count < 1000);
            if ($urandom_range(99) < 15) begin
                drain_and_settle();
                load_random_settings();
            end
            if (word_count >= 1200 && word_count < 1400) begin
                // Pressure window: a burst of one- and two-word vectors against the hold-off.
                pressure_on = 1'b1;
                repeat (60) stream_vector($urandom_range(2, 1), 1'b0);
                pressure_on = 1'b0;
            end
            len = ($urandom_range(9) == 0) ? $urandom_range(64, 13) : $urandom_range(12, 1);
            stream_vector(len, 1'b0);
        end
        steady = 1'b0;

        // A vector built from the largest possible squared differences.
        drain_and_settle();
        load_settings(ETYPE_S16, {1'b0, METRIC_L2});
        stream_vector(64, 1'b1);

        drain_and_settle();
        $display("Run covered %0d input words and %0d result words over all element types,",
                 words_seen, results_seen);
        $display("both metrics, mid-vector setting changes, extreme 16-bit terms and a long stall.");
        if (mismatches == 0) begin
            $display("vector_distance_accumulator verification clean");
        end else begin
            $display("vector_distance_accumulator verification failed");
        end
        $finish;
    end

    // Watchdog: the slowest correct run stays far below this.
    initial begin
        #10_000_000;
        $display("vector_distance_accumulator verification failed");
        $finish;
    end

endmodule
